[sv/nsp_pkg.sv]
// Package: shared types, constants and control structs for the nearest segment pick unit.
package nsp_pkg;

  localparam int MAX_LINES_DEF  = 4096;
  localparam int COORD_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 4;
  localparam int SLACK_BITS     = 16;
  localparam int COUNT_BITS     = 13;
  localparam int INDEX_BITS     = 12;
  localparam int CFG_IDX_BITS   = 1;
  localparam int CFG_DATA_BITS  = 16;
  localparam logic [15:0] SLACK_RESET = 16'd18;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  localparam logic [CFG_IDX_BITS-1:0] CFG_SLACK      = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LINE_COUNT = 1'b1;

  typedef struct packed {
    logic               action;
    logic [11:0]        entry_index;
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
    logic signed [15:0] end_x;
    logic signed [15:0] end_y;
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
  } in_word_t;

  typedef struct packed {
    logic        found;
    logic [11:0] line_index;
    logic [19:0] distance;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_WRITE, ST_RD, ST_GEO, ST_MUL, ST_PREP, ST_ITER, ST_CMP, ST_OUT
  } nsp_state_t;

  // controller -> datapath
  typedef struct packed {
    logic load_query;
    logic do_write;
    logic rd_entry;
    logic geo;
    logic mul;
    logic prep;
    logic iter;
    logic cmp;
    logic clr_best;
    logic load_out;
  } nsp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic iter_done;
    logic scan_last;
    logic scan_empty;
  } nsp_sts_t;

endpackage

[sv/nsp_datapath.sv]
// Datapath: segment memory, per-entry distance arithmetic with an iterative root/divide unit.
module nsp_datapath #(
  parameter int MAX_LINES  = nsp_pkg::MAX_LINES_DEF,
  parameter int COORD_BITS = nsp_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = nsp_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  nsp_pkg::nsp_cmd_t                   cmd,
  output nsp_pkg::nsp_sts_t                   sts,
  input  nsp_pkg::in_word_t                   in_word,
  input  logic [nsp_pkg::SLACK_BITS-1:0]      slack,
  input  logic [nsp_pkg::COUNT_BITS-1:0]      line_count,
  output nsp_pkg::out_word_t                  res
);
  import nsp_pkg::*;

  localparam int AW   = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
  localparam int CW   = $clog2(MAX_LINES + 1);
  localparam int DW   = COORD_BITS + 2;            // coordinate differences
  localparam int PW   = 2 * DW;                    // products
  localparam int SW   = 2 * COORD_BITS + 2 + 2 * FRAC_BITS; // radicand
  localparam int RW   = (SW + 1) / 2;              // root width
  localparam int NW   = PW + FRAC_BITS;            // dividend width
  localparam int IW   = (NW > SW) ? NW : SW;
  localparam int QW   = COORD_BITS + FRAC_BITS + 2;
  localparam int ENTW = 4 * COORD_BITS;
  localparam int LW   = (CW > COUNT_BITS) ? CW : COUNT_BITS;
  localparam int KW   = $clog2(IW + 1);

  logic [ENTW-1:0] mem [MAX_LINES];
  logic [ENTW-1:0] rd_r;
  logic [AW-1:0]   scan_r;
  logic [CW-1:0]   limit_r;
  logic signed [COORD_BITS-1:0] px_r, py_r;

  always_ff @(posedge clk) begin
    if (cmd.do_write && (32'(in_word.entry_index) < MAX_LINES)) begin
      mem[AW'(in_word.entry_index)] <= {COORD_BITS'(in_word.start_x), COORD_BITS'(in_word.start_y),
                                        COORD_BITS'(in_word.end_x), COORD_BITS'(in_word.end_y)};
    end
    if (cmd.rd_entry) begin
      rd_r <= mem[scan_r];
    end
  end

  logic signed [COORD_BITS-1:0] x1, y1, x2, y2;
  assign {x1, y1, x2, y2} = rd_r;

  logic [LW-1:0] lc_ext;
  assign lc_ext = LW'(line_count);

  always_ff @(posedge clk) begin
    if (cmd.load_query) begin
      px_r    <= COORD_BITS'(in_word.point_x);
      py_r    <= COORD_BITS'(in_word.point_y);
      limit_r <= (lc_ext > LW'(MAX_LINES)) ? CW'(MAX_LINES) : CW'(lc_ext);
      scan_r  <= '0;
    end else if (cmd.cmp) begin
      scan_r  <= scan_r + AW'(1);
    end
  end

  assign sts.scan_empty = (limit_r == '0);
  assign sts.scan_last  = ((CW+1)'(scan_r) + (CW+1)'(1)) >= (CW+1)'(limit_r);

  // geometry stage
  logic signed [DW-1:0] dx, dy, ex, ey, ax_d, ay_d, bx_d, by_d;
  logic [DW-1:0] adx, ady;
  logic          horiz, zero, use_ep;
  always_comb begin
    dx = DW'(x2) - DW'(x1);
    dy = DW'(y2) - DW'(y1);
    adx = dx[DW-1] ? -dx : dx;
    ady = dy[DW-1] ? -dy : dy;
    zero = (dx == '0) && (dy == '0);
    horiz = adx > ady;
    use_ep = 1'b1;
    ex = DW'(px_r) - DW'(x1);
    ey = DW'(py_r) - DW'(y1);
    ax_d = ex; ay_d = dy; bx_d = ey; by_d = dx;
    if (!zero) begin
      if (horiz) begin
        if (DW'(px_r) < (dx > 0 ? DW'(x1) : DW'(x2))) begin
          ex = DW'(px_r) - (dx > 0 ? DW'(x1) : DW'(x2));
          ey = DW'(py_r) - (dx > 0 ? DW'(y1) : DW'(y2));
        end else if (DW'(px_r) > (dx > 0 ? DW'(x2) : DW'(x1))) begin
          ex = DW'(px_r) - (dx > 0 ? DW'(x2) : DW'(x1));
          ey = DW'(py_r) - (dx > 0 ? DW'(y2) : DW'(y1));
        end else begin
          use_ep = 1'b0;
          ax_d = DW'(px_r) - DW'(x1); ay_d = dy;
          bx_d = DW'(py_r) - DW'(y1); by_d = dx;
        end
      end else begin
        if (DW'(py_r) < (dy > 0 ? DW'(y1) : DW'(y2))) begin
          ex = DW'(px_r) - (dy > 0 ? DW'(x1) : DW'(x2));
          ey = DW'(py_r) - (dy > 0 ? DW'(y1) : DW'(y2));
        end else if (DW'(py_r) > (dy > 0 ? DW'(y2) : DW'(y1))) begin
          ex = DW'(px_r) - (dy > 0 ? DW'(x2) : DW'(x1));
          ey = DW'(py_r) - (dy > 0 ? DW'(y2) : DW'(y1));
        end else begin
          use_ep = 1'b0;
          ax_d = DW'(py_r) - DW'(y1); ay_d = dx;
          bx_d = DW'(px_r) - DW'(x1); by_d = dy;
        end
      end
    end
  end

  logic signed [DW-1:0] ma_r, mb_r, mc_r, md_r;
  logic [DW-1:0]        den_r;
  logic                 ep_r;
  always_ff @(posedge clk) begin
    if (cmd.geo) begin
      ep_r  <= use_ep;
      den_r <= horiz ? adx : ady;
      if (use_ep) begin
        ma_r <= ex; mb_r <= ex; mc_r <= ey; md_r <= ey;
      end else begin
        ma_r <= ax_d; mb_r <= ay_d; mc_r <= bx_d; md_r <= by_d;
      end
    end
  end

  // multiply stage: two products, registered
  logic signed [PW-1:0] p1_r, p2_r;
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      p1_r <= PW'(ma_r) * PW'(mb_r);
      p2_r <= PW'(mc_r) * PW'(md_r);
    end
  end

  // operand prep for the shared iterative unit
  logic signed [PW:0] diff;
  logic [PW:0]        mag_n;
  assign diff  = (PW+1)'(p1_r) - (PW+1)'(p2_r);
  assign mag_n = diff[PW] ? -diff : diff;

  logic [IW-1:0] num_r, rem_r, quo_r, bit_r;
  logic [DW-1:0] dv_r;
  logic [KW-1:0] cnt_r;
  logic          mode_ep_r;

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      mode_ep_r <= ep_r;
      dv_r      <= den_r;
      quo_r     <= '0;
      if (ep_r) begin
        num_r <= IW'({(PW+1)'(p1_r) + (PW+1)'(p2_r), {(2*FRAC_BITS){1'b0}}});
        bit_r <= IW'(1) << (2 * (RW - 1));
        cnt_r <= KW'(RW);
      end else begin
        num_r <= IW'({mag_n, {FRAC_BITS{1'b0}}});
        rem_r <= '0;
        cnt_r <= KW'(NW);
      end
    end else if (cmd.iter) begin
      cnt_r <= cnt_r - KW'(1);
      if (mode_ep_r) begin
        if (num_r >= quo_r + bit_r) begin
          num_r <= num_r - (quo_r + bit_r);
          quo_r <= (quo_r >> 1) + bit_r;
        end else begin
          quo_r <= quo_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end else begin
        if ({rem_r[IW-2:0], num_r[NW-1]} >= IW'(dv_r)) begin
          rem_r <= {rem_r[IW-2:0], num_r[NW-1]} - IW'(dv_r);
          quo_r <= {quo_r[IW-2:0], 1'b1};
        end else begin
          rem_r <= {rem_r[IW-2:0], num_r[NW-1]};
          quo_r <= {quo_r[IW-2:0], 1'b0};
        end
        num_r <= num_r << 1;
      end
    end
  end

  assign sts.iter_done = (cnt_r == KW'(1));

  // best tracking
  logic [QW+SLACK_BITS-1:0] acc_lim, dcur;
  assign acc_lim = (QW+SLACK_BITS)'(slack) << FRAC_BITS;
  assign dcur    = (QW+SLACK_BITS)'(quo_r);

  logic                       have_r;
  logic [AW-1:0]              bidx_r;
  logic [QW+SLACK_BITS-1:0]   bd_r;
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clr_best) begin
      have_r <= 1'b0;
      bidx_r <= '0;
      bd_r   <= '0;
    end else if (cmd.cmp && (dcur <= acc_lim) && (!have_r || dcur <= bd_r)) begin
      have_r <= 1'b1;
      bidx_r <= scan_r;
      bd_r   <= dcur;
    end
  end

  // output word register, frees the scan for the next query
  out_word_t out_r;
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_r.found      <= have_r;
      out_r.line_index <= have_r ? INDEX_BITS'(bidx_r) : '0;
      out_r.distance   <= have_r ? 20'(bd_r) : '0;
    end
  end

  assign res = out_r;
endmodule

[sv/nsp_ctrl.sv]
// Controller: sequences writes and per-entry query scan steps, owns the handshakes.
module nsp_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_action,
  output logic                 out_valid,
  input  logic                 out_ready,
  output nsp_pkg::nsp_cmd_t    cmd,
  input  nsp_pkg::nsp_sts_t    sts
);
  import nsp_pkg::*;

  nsp_state_t state_r, state_nxt;
  logic       out_full_r, out_full_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      out_full_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      out_full_r <= out_full_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    in_ready     = 1'b0;
    out_valid    = out_full_r;
    out_full_nxt = out_full_r && !out_ready;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_action == ACT_WRITE) begin
            cmd.do_write = 1'b1;
          end else begin
            cmd.load_query = 1'b1;
            cmd.clr_best   = 1'b1;
            state_nxt      = ST_WRITE;
          end
        end
      end
      ST_WRITE: begin
        state_nxt = sts.scan_empty ? ST_OUT : ST_RD;
      end
      ST_RD: begin
        cmd.rd_entry = 1'b1;
        state_nxt    = ST_GEO;
      end
      ST_GEO: begin
        cmd.geo   = 1'b1;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_PREP;
      end
      ST_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = ST_ITER;
      end
      ST_ITER: begin
        cmd.iter = 1'b1;
        if (sts.iter_done) begin
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        cmd.cmp   = 1'b1;
        state_nxt = sts.scan_last ? ST_OUT : ST_RD;
      end
      ST_OUT: begin
        if (!out_full_r || out_ready) begin
          cmd.load_out = 1'b1;
          out_full_nxt = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule

[sv/nearest_segment_pick_unit.sv]
// Top level: nearest line segment search over a table of stored segments.
// A write word stores one segment as it is accepted. A query word scans entries 0 to
// min(line_count, MAX_LINES)-1 one at a time; each entry passes the read, geometry,
// multiply, prep and compare states plus the steps of the shared iterative unit: 40
// divide steps for a line offset or 21 root steps for an endpoint distance at default
// widths. The result waits in an output register, so a stalled output holds back only
// a query that finishes while the previous result is still unread.
module nearest_segment_pick_unit #(
  parameter int MAX_LINES  = nsp_pkg::MAX_LINES_DEF,
  parameter int COORD_BITS = nsp_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = nsp_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  nsp_pkg::in_word_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output nsp_pkg::out_word_t                  out_data,
  input  logic                                cfg_we,
  input  logic [nsp_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [nsp_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
  import nsp_pkg::*;

  logic [SLACK_BITS-1:0] slack_r;
  logic [COUNT_BITS-1:0] line_count_r;
  nsp_cmd_t cmd;
  nsp_sts_t sts;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slack_r      <= SLACK_RESET;
      line_count_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SLACK:      slack_r      <= cfg_data;
        CFG_LINE_COUNT: line_count_r <= COUNT_BITS'(cfg_data);
        default: ;
      endcase
    end
  end

  nsp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_action (in_data.action),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  nsp_datapath #(
    .MAX_LINES  (MAX_LINES),
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_word    (in_data),
    .slack      (slack_r),
    .line_count (line_count_r),
    .res        (out_data)
  );
endmodule

[tb/sv/tb.sv]
// Testbench for nearest_segment_pick_unit: segment writes and point queries checked by a scoreboard.
`timescale 1ns / 1ps

module tb;
  import nsp_pkg::*;

  localparam int TABLE_DEPTH = 4096;
  localparam int FILL_COUNT  = 24;

  class pick_board;
    int sx[TABLE_DEPTH];
    int sy[TABLE_DEPTH];
    int ex[TABLE_DEPTH];
    int ey[TABLE_DEPTH];
    logic [15:0] slack_val = SLACK_RESET;
    logic [12:0] count_val = '0;
    out_word_t picks[$];
    int errors = 0;

    function longint unsigned root_floor(longint unsigned s);
      longint unsigned r = 0;
      longint unsigned b = 64'h4000_0000_0000_0000;
      while (b > s) b >>= 2;
      while (b != 0) begin
        if (s >= r + b) begin
          s -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function longint unsigned tip_dist(longint dx, longint dy);
      longint unsigned s;
      s = dx * dx + dy * dy;
      return root_floor(s << 8);
    endfunction

    function longint unsigned seg_metric(longint px, longint py, longint x1,
                                         longint y1, longint x2, longint y2);
      longint dx, dy, adx, ady, num, lox, loy, hix, hiy;
      dx = x2 - x1;
      dy = y2 - y1;
      adx = dx < 0 ? -dx : dx;
      ady = dy < 0 ? -dy : dy;
      if (dx == 0 && dy == 0) return tip_dist(px - x1, py - y1);
      if (adx > ady) begin
        lox = dx > 0 ? x1 : x2; loy = dx > 0 ? y1 : y2;
        hix = dx > 0 ? x2 : x1; hiy = dx > 0 ? y2 : y1;
        if (px < lox) return tip_dist(px - lox, py - loy);
        if (px > hix) return tip_dist(px - hix, py - hiy);
        num = (px - x1) * dy - (py - y1) * dx;
        if (num < 0) num = -num;
        return (num << 4) / adx;
      end else begin
        lox = dy > 0 ? x1 : x2; loy = dy > 0 ? y1 : y2;
        hix = dy > 0 ? x2 : x1; hiy = dy > 0 ? y2 : y1;
        if (py < loy) return tip_dist(px - lox, py - loy);
        if (py > hiy) return tip_dist(px - hix, py - hiy);
        num = (py - y1) * dx - (px - x1) * dy;
        if (num < 0) num = -num;
        return (num << 4) / ady;
      end
    endfunction

    function void note_input(in_word_t w);
      int lim;
      longint unsigned d, best_d, accept;
      bit have;
      out_word_t r;
      if (w.action == ACT_WRITE) begin
        sx[w.entry_index] = w.start_x;
        sy[w.entry_index] = w.start_y;
        ex[w.entry_index] = w.end_x;
        ey[w.entry_index] = w.end_y;
        return;
      end
      lim = count_val > TABLE_DEPTH ? TABLE_DEPTH : count_val;
      accept = longint'(slack_val) << 4;
      have = 0;
      best_d = 0;
      r = '0;
      for (int n = 0; n < lim; n++) begin
        d = seg_metric(w.point_x, w.point_y, sx[n], sy[n], ex[n], ey[n]);
        if (d <= accept && (!have || d <= best_d)) begin
          have = 1;
          best_d = d;
          r.line_index = n[11:0];
        end
      end
      r.found = have;
      r.distance = best_d[19:0];
      picks.push_back(r);
    endfunction

    function void check_result(out_word_t got);
      out_word_t want;
      if (picks.size() == 0) begin
        $error("unexpected result word %h", got);
        errors++;
        return;
      end
      want = picks.pop_front();
      if (got.found !== want.found) begin
        $error("found: expected %0d, got %0d", want.found, got.found);
        errors++;
      end
      if (got.line_index !== want.line_index) begin
        $error("line_index: expected %0d, got %0d", want.line_index, got.line_index);
        errors++;
      end
      if (got.distance !== want.distance) begin
        $error("distance: expected %0d, got %0d", want.distance, got.distance);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_ready = 0;
  out_word_t out_data;
  logic cfg_we = 0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;
  bit long_hold = 0;
  pick_board board = new();

  nearest_segment_pick_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) board.check_result(out_data);
  end

  function automatic int short_or_long_gap();
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 80);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  // receiver: random stalls, and a long hold when asked
  initial begin
    int n;
    @(posedge rst_n);
    forever begin
      if (long_hold) begin
        @(negedge clk) out_ready <= 0;
        repeat (4000) @(negedge clk);
        long_hold = 0;
      end else begin
        n = short_or_long_gap();
        if (n > 0) begin
          @(negedge clk) out_ready <= 0;
          repeat (n - 1) @(negedge clk);
        end
        @(negedge clk) out_ready <= 1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  // called at a falling edge; returns at a falling edge
  task automatic send_word(input in_word_t w, input int gap);
    in_valid <= 1;
    in_data <= w;
    do @(posedge clk); while (!in_ready);
    board.note_input(w);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic write_cfg(input logic [CFG_IDX_BITS-1:0] idx, input logic [15:0] v);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    if (idx == CFG_SLACK) board.slack_val = v;
    else board.count_val = v[12:0];
    @(negedge clk);
    cfg_we <= 0;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (board.picks.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  function automatic in_word_t noise_word();
    logic [127:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom};
    return raw[$bits(in_word_t)-1:0];
  endfunction

  function automatic in_word_t seg_word(int idx, int x1, int y1, int x2, int y2);
    in_word_t w;
    w = noise_word();
    w.action = ACT_WRITE;
    w.entry_index = idx[11:0];
    w.start_x = x1[15:0]; w.start_y = y1[15:0];
    w.end_x = x2[15:0]; w.end_y = y2[15:0];
    return w;
  endfunction

  function automatic in_word_t point_word(int x, int y);
    in_word_t w;
    w = noise_word();
    w.action = ACT_QUERY;
    w.point_x = x[15:0];
    w.point_y = y[15:0];
    return w;
  endfunction

  function automatic in_word_t near_query(int lc);
    int k, t, x, y;
    k = $urandom_range(0, lc - 1);
    t = $urandom_range(0, 16);
    x = board.sx[k] + ((board.ex[k] - board.sx[k]) * t) / 16
        + int'($urandom_range(0, 40)) - 20;
    y = board.sy[k] + ((board.ey[k] - board.sy[k]) * t) / 16
        + int'($urandom_range(0, 40)) - 20;
    return point_word(x, y);
  endfunction

  function automatic in_word_t rand_seg(int idx);
    int cx, cy;
    if ($urandom_range(0, 9) == 0)
      return seg_word(idx, $signed($urandom_range(0, 65535) - 32768),
                      $signed($urandom_range(0, 65535) - 32768),
                      $signed($urandom_range(0, 65535) - 32768),
                      $signed($urandom_range(0, 65535) - 32768));
    cx = $urandom_range(0, 4000) - 2000;
    cy = $urandom_range(0, 4000) - 2000;
    if ($urandom_range(0, 15) == 0)
      return seg_word(idx, cx, cy, cx, cy);
    return seg_word(idx, cx, cy, cx + $urandom_range(0, 300) - 150,
                    cy + $urandom_range(0, 300) - 150);
  endfunction

  initial begin
    int lc, done, burst;
    repeat (4) @(posedge clk);
    @(negedge clk) rst_n <= 1;
    @(negedge clk);

    // empty table search
    send_word(point_word(0, 0), 0);
    send_word(seg_word(0, 0, 0, 100, 0), 1);
    send_word(seg_word(1, 100, 0, 0, 0), 0);
    send_word(seg_word(2, 50, 50, 50, 50), 2);
    send_word(seg_word(3, 10, -50, 10, 50), 0);
    send_word(seg_word(4, -32768, -32768, 32767, 32767), 0);
    send_word(seg_word(5, 32767, -32768, -32768, 32767), 0);
    drain();
    write_cfg(CFG_LINE_COUNT, 16'd6);
    send_word(point_word(50, 3), 0);
    send_word(point_word(-5, 4), 1);
    send_word(point_word(100, 7), 0);
    send_word(point_word(120, 0), 0);
    send_word(point_word(53, 52), 3);
    send_word(point_word(10, 60), 0);
    send_word(point_word(12, 0), 0);
    send_word(point_word(10000, 10000), 0);
    drain();
    write_cfg(CFG_SLACK, 16'hFFFF);
    send_word(point_word(-32768, 32767), 0);
    send_word(point_word(32767, -32768), 0);
    send_word(point_word(32767, 32767), 0);
    drain();
    write_cfg(CFG_SLACK, 16'd0);
    send_word(point_word(50, 0), 0);
    send_word(point_word(50, 1), 0);
    drain();

    // fill the slots that the random bursts search
    for (int i = 0; i < FILL_COUNT; i++) send_word(rand_seg(i), 0);
    drain();

    done = 0;
    burst = 0;
    while (done < 96) begin
      lc = $urandom_range(1, FILL_COUNT);
      write_cfg(CFG_LINE_COUNT, {3'($urandom_range(0, 7)), 13'(lc)});
      case ($urandom_range(0, 5))
        0: write_cfg(CFG_SLACK, 16'd0);
        1: write_cfg(CFG_SLACK, 16'hFFFF);
        2: write_cfg(CFG_SLACK, 16'($urandom));
        default: write_cfg(CFG_SLACK, 16'($urandom_range(1, 60)));
      endcase
      if (burst == 2) long_hold = 1;
      repeat ($urandom_range(6, 14)) begin
        case ($urandom_range(0, 9))
          0, 1: send_word(rand_seg($urandom_range(0, lc - 1)), short_or_long_gap());
          2: send_word(rand_seg($urandom_range(0, TABLE_DEPTH - 1)), short_or_long_gap());
          3: send_word(point_word($signed($urandom_range(0, 65535) - 32768),
                                  $signed($urandom_range(0, 65535) - 32768)),
                       short_or_long_gap());
          default: send_word(near_query(lc), burst == 2 ? 0 : short_or_long_gap());
        endcase
        done++;
      end
      burst++;
      drain();
    end

    if (board.errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #60_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
